FILE: rtl/core/tbk_pkg.sv
// Shared types and constants for the trimmed peak average block.
// Used by every module under rtl/core; depends on nothing.
package tbk_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOP_W    = 15;

  localparam logic signed [SAMPLE_W-1:0] KEY_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] TOP_FILL = 16'sh0000;
  // Bottom side keeps complemented keys; the complement of zero is all ones.
  localparam logic signed [SAMPLE_W-1:0] BOT_FILL = 16'shFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic [TOP_W-1:0]           top_average;
    logic signed [SAMPLE_W-1:0] bottom_average;
  } out_t;

  typedef struct packed {
    logic take;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic ld_mult;
    logic ld_out;
  } lane_en_t;

endpackage

FILE: rtl/core/tbk_cell.sv
// One slot of the sorted keep list: holds a key and takes either the new key
// or its upstream neighbor's key. Depends on tbk_pkg.
module tbk_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tbk_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [tbk_pkg::SAMPLE_W-1:0] key,
  input  logic signed [tbk_pkg::SAMPLE_W-1:0] up_val,
  input  logic signed [tbk_pkg::SAMPLE_W-1:0] fill_val,
  output logic signed [tbk_pkg::SAMPLE_W-1:0] val
);

  logic signed [tbk_pkg::SAMPLE_W-1:0] val_r;
  logic signed [tbk_pkg::SAMPLE_W-1:0] val_nxt;

  // Shift the upstream key down when the new key outranks both.
  always_comb begin
    if (key > val_r) begin
      val_nxt = (key > up_val) ? up_val : key;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= fill_val;
    end else if (ctrl.clear) begin
      val_r <= fill_val;
    end else if (ctrl.take) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

FILE: rtl/core/tbk_chain.sv
// Row of tbk_cell slots kept in descending key order.
// Depends on tbk_pkg and tbk_cell.
module tbk_chain #(
  parameter int KEEP_COUNT = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tbk_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [tbk_pkg::SAMPLE_W-1:0] key,
  input  logic signed [tbk_pkg::SAMPLE_W-1:0] fill_val,
  output logic signed [tbk_pkg::SAMPLE_W-1:0] head_nxt,
  output logic signed [tbk_pkg::SAMPLE_W-1:0] tail
);

  logic signed [tbk_pkg::SAMPLE_W-1:0] vals [KEEP_COUNT];

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      tbk_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .key      (key),
        .up_val   (tbk_pkg::KEY_MAX),
        .fill_val (fill_val),
        .val      (vals[i])
      );
    end else begin : g_body
      tbk_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .key      (key),
        .up_val   (vals[i-1]),
        .fill_val (fill_val),
        .val      (vals[i])
      );
    end
  end

  // The head takes the new key whenever the key outranks it.
  assign head_nxt = (key > vals[0]) ? key : vals[0];
  assign tail     = vals[KEEP_COUNT-1];

endmodule

FILE: rtl/core/tbk_div_lane.sv
// Floor division of a signed sum by a constant: bias, reciprocal multiply,
// one-step correction. Two register stages. Depends on tbk_pkg.
module tbk_div_lane #(
  parameter int SUM_W = 19,
  parameter int DIV   = 4
) (
  input  logic                    clk,
  input  tbk_pkg::lane_en_t       en,
  input  logic signed [SUM_W-1:0] num,
  output logic signed [SUM_W-1:0] quot
);

  localparam int DIV_BITS = (DIV > 1) ? $clog2(DIV) : 0;
  localparam int BW       = SUM_W + DIV_BITS + 1;
  localparam logic [BW:0]   RECIP = (BW+1)'((64'd1 << BW) / DIV);
  localparam logic [BW-1:0] OFF_V = BW'(DIV) << (SUM_W - 1);

  logic [BW-1:0]    nb;
  logic [2*BW:0]    prod_nxt;
  logic [BW-1:0]    nb_r;
  logic [2*BW:0]    prod_r;
  logic [SUM_W-1:0] q_est;
  logic [BW-1:0]    rem;
  logic [SUM_W-1:0] q_fix;
  logic [SUM_W-1:0] quot_r;

  // Bias makes the sum nonnegative; the bias divides out exactly.
  assign nb       = BW'(num) + OFF_V;
  assign prod_nxt = (2*BW+1)'(nb) * (2*BW+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en.ld_mult) begin
      nb_r   <= nb;
      prod_r <= prod_nxt;
    end
  end

  // Estimate is exact or one low; fix with a single remainder compare.
  assign q_est = prod_r[BW +: SUM_W];
  assign rem   = nb_r - BW'(q_est) * BW'(DIV);
  assign q_fix = (rem >= BW'(DIV)) ? q_est + SUM_W'(1) : q_est;

  always_ff @(posedge clk) begin
    if (en.ld_out) begin
      // Remove the bias quotient by flipping the top bit.
      quot_r <= q_fix ^ {1'b1, {(SUM_W-1){1'b0}}};
    end
  end

  assign quot = $signed(quot_r);

endmodule

FILE: rtl/core/top_bottom_k_trimmed_peak_average.sv
// Trimmed peak averages over a frame of signed Q8.8 samples: top level.
// Depends on tbk_pkg, tbk_chain (with tbk_cell) and tbk_div_lane.
//
// One sample transfers per clock, with no gaps needed between samples or
// frames. Two rows of KEEP_COUNT cells keep the largest positive and the most
// negative samples in sorted order; every cell compares against the incoming
// sample in the same cycle and takes either it or its neighbor's value. The
// bottom row holds complemented samples so both rows share one cell design.
// Running totals per row track the sum. On the transfer that carries last,
// the trimmed sums (total minus the extreme entry) are captured and the rows
// clear for the next frame. The result then passes three registers in order:
// the sum capture, the reciprocal multiply, and the remainder correction
// into the output register. Up to three results can be in flight, so input
// stall rises only when all three stages are full behind a stalled output.
module top_bottom_k_trimmed_peak_average #(
  parameter int KEEP_COUNT = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tbk_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tbk_pkg::out_t out_data
);

  localparam int SUM_W = tbk_pkg::SAMPLE_W + $clog2(KEEP_COUNT);
  localparam int DIV   = KEEP_COUNT - 1;

  logic                                in_xfer;
  tbk_pkg::cell_ctrl_t                 ctrl;
  logic signed [tbk_pkg::SAMPLE_W-1:0] bot_key;
  logic signed [tbk_pkg::SAMPLE_W-1:0] top_head_nxt;
  logic signed [tbk_pkg::SAMPLE_W-1:0] top_tail;
  logic signed [tbk_pkg::SAMPLE_W-1:0] bot_head_nxt;
  logic signed [tbk_pkg::SAMPLE_W-1:0] bot_tail;

  logic signed [SUM_W-1:0] top_tot_r, top_tot_nxt;
  logic signed [SUM_W-1:0] bot_tot_r, bot_tot_nxt;
  logic signed [16:0]      top_delta, bot_delta;

  logic signed [SUM_W-1:0] top_trim_r, bot_trim_r;
  logic signed [SUM_W-1:0] top_quot, bot_quot;

  logic              s1_valid_r, s2_valid_r, out_valid_r;
  logic              ld1;
  tbk_pkg::lane_en_t en;
  logic              free1, free2, free3;

  // Accept a sample whenever the capture stage can take or pass on a result.
  assign free3    = !out_valid_r || !out_stall;
  assign en.ld_out  = s2_valid_r && free3;
  assign free2    = !s2_valid_r || en.ld_out;
  assign en.ld_mult = s1_valid_r && free2;
  assign free1    = !s1_valid_r || en.ld_mult;
  assign in_stall = !free1;

  assign in_xfer    = in_valid && !in_stall;
  assign ctrl.take  = in_xfer;
  assign ctrl.clear = in_xfer && in_data.last;
  assign ld1        = in_xfer && in_data.last;

  // Complement the sample so the bottom row also sorts in descending order.
  assign bot_key = ~in_data.sample;

  tbk_chain #(.KEEP_COUNT(KEEP_COUNT)) u_top_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .key      (in_data.sample),
    .fill_val (tbk_pkg::TOP_FILL),
    .head_nxt (top_head_nxt),
    .tail     (top_tail)
  );

  tbk_chain #(.KEEP_COUNT(KEEP_COUNT)) u_bot_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .key      (bot_key),
    .fill_val (tbk_pkg::BOT_FILL),
    .head_nxt (bot_head_nxt),
    .tail     (bot_tail)
  );

  // Running totals: an insertion adds the sample and drops the tail entry.
  assign top_delta = $signed({in_data.sample[15], in_data.sample})
                   - $signed({top_tail[15], top_tail});
  assign bot_delta = $signed({in_data.sample[15], in_data.sample})
                   - $signed({~bot_tail[15], ~bot_tail});

  always_comb begin
    top_tot_nxt = top_tot_r;
    bot_tot_nxt = bot_tot_r;
    if (in_data.sample > top_tail) begin
      top_tot_nxt = top_tot_r + SUM_W'(top_delta);
    end
    if (bot_key > bot_tail) begin
      bot_tot_nxt = bot_tot_r + SUM_W'(bot_delta);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_tot_r <= '0;
      bot_tot_r <= '0;
    end else if (ctrl.clear) begin
      top_tot_r <= '0;
      bot_tot_r <= '0;
    end else if (ctrl.take) begin
      top_tot_r <= top_tot_nxt;
      bot_tot_r <= bot_tot_nxt;
    end
  end

  // Capture the trimmed sums: drop the row's extreme entry, held at the head.
  always_ff @(posedge clk) begin
    if (ld1) begin
      top_trim_r <= top_tot_nxt - SUM_W'(top_head_nxt);
      bot_trim_r <= bot_tot_nxt - SUM_W'(~bot_head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid_r <= 1'b1;
      end else if (en.ld_mult) begin
        s1_valid_r <= 1'b0;
      end
      if (en.ld_mult) begin
        s2_valid_r <= 1'b1;
      end else if (en.ld_out) begin
        s2_valid_r <= 1'b0;
      end
      if (en.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  tbk_div_lane #(.SUM_W(SUM_W), .DIV(DIV)) u_top_div (
    .clk  (clk),
    .en   (en),
    .num  (top_trim_r),
    .quot (top_quot)
  );

  tbk_div_lane #(.SUM_W(SUM_W), .DIV(DIV)) u_bot_div (
    .clk  (clk),
    .en   (en),
    .num  (bot_trim_r),
    .quot (bot_quot)
  );

  // Both averages fit their fields; keep the low bits.
  assign out_valid               = out_valid_r;
  assign out_data.top_average    = top_quot[tbk_pkg::TOP_W-1:0];
  assign out_data.bottom_average = bot_quot[tbk_pkg::SAMPLE_W-1:0];

endmodule

FILE: dv/tb.sv
// Testbench for top_bottom_k_trimmed_peak_average: directed frames, then random frames.
// Depends on tbk_pkg and the block's RTL. A local predictor checks every result transfer.
`timescale 1ns / 100ps

module tb;

  localparam int KEEP        = 5;
  localparam int DIVISOR     = KEEP - 1;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  tbk_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  tbk_pkg::out_t out_data;

  // Percent of cycles in which each side holds off; changed per phase.
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;

  // Predictor state: the two kept rows and their current thresholds.
  int top_keep [KEEP];
  int bot_keep [KEEP];
  int top_low;
  int bot_high;
  tbk_pkg::out_t avg_expected [$];

  top_bottom_k_trimmed_peak_average #(.KEEP_COUNT(KEEP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Randomize the result-side stall at each edge; hold it low during reset.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Floor division, so a negative trimmed sum rounds away from zero.
  function automatic int floor_quot(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic void clear_rows();
    for (int i = 0; i < KEEP; i++) begin
      top_keep[i] = 0;
      bot_keep[i] = 0;
    end
    top_low  = 0;
    bot_high = 0;
  endfunction

  // Fold one accepted sample into the rows; on last, queue the trimmed averages.
  function automatic void absorb_sample(tbk_pkg::in_t item);
    int            s;
    int            lo;
    int            hi;
    int            tsum;
    int            bsum;
    int            tmax;
    int            bmin;
    int            ta;
    int            ba;
    bit            done;
    tbk_pkg::out_t res;
    s = item.sample;
    done = 1'b0;
    if (s > top_low) begin
      lo = 32767;
      for (int i = 0; i < KEEP; i++) begin
        if (!done && top_keep[i] == top_low) begin
          top_keep[i] = s;
          done = 1'b1;
        end
        if (top_keep[i] < lo) lo = top_keep[i];
      end
      top_low = lo;
    end else if (s < bot_high) begin
      hi = -32768;
      for (int i = 0; i < KEEP; i++) begin
        if (!done && bot_keep[i] == bot_high) begin
          bot_keep[i] = s;
          done = 1'b1;
        end
        if (bot_keep[i] > hi) hi = bot_keep[i];
      end
      bot_high = hi;
    end
    if (item.last) begin
      tsum = 0;
      bsum = 0;
      tmax = 0;
      bmin = 0;
      for (int i = 0; i < KEEP; i++) begin
        tsum += top_keep[i];
        bsum += bot_keep[i];
        if (top_keep[i] > tmax) tmax = top_keep[i];
        if (bot_keep[i] < bmin) bmin = bot_keep[i];
      end
      ta = floor_quot(tsum - tmax, DIVISOR);
      ba = floor_quot(bsum - bmin, DIVISOR);
      res.top_average    = ta[tbk_pkg::TOP_W-1:0];
      res.bottom_average = ba[tbk_pkg::SAMPLE_W-1:0];
      avg_expected.push_back(res);
      clear_rows();
    end
  endfunction

  // Send one sample. Enter and leave at a rising edge. Valid is only lowered
  // on idle cycles, so back-to-back transfers never see two assignments of
  // in_valid in one step. Stall is sampled at the falling edge, where both
  // sides have settled for the coming rising edge.
  task automatic send_sample(input int s, input bit last);
    tbk_pkg::in_t item;
    item.sample = s[tbk_pkg::SAMPLE_W-1:0];
    item.last   = last;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    absorb_sample(item);
  endtask

  // Check each result transfer against the oldest expectation. Sample at the
  // falling edge; the transfer itself completes at the next rising edge.
  always @(negedge clk) begin
    tbk_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expected.size() == 0) begin
        $error("unexpected result: top_average=%0d bottom_average=%0d",
               out_data.top_average, out_data.bottom_average);
        error_count++;
      end else begin
        want = avg_expected.pop_front();
        if (out_data.top_average !== want.top_average) begin
          $error("top_average: expected %0d, got %0d",
                 want.top_average, out_data.top_average);
          error_count++;
        end
        if (out_data.bottom_average !== want.bottom_average) begin
          $error("bottom_average: expected %0d, got %0d",
                 want.bottom_average, out_data.bottom_average);
          error_count++;
        end
      end
    end
  end

  // Zero-only frames: nothing enters either row, so both averages are zero.
  task automatic test_empty_frames();
    send_sample(0, 1'b1);
    send_sample(0, 1'b0);
    send_sample(0, 1'b1);
  endtask

  // Full-scale samples on both sides, interleaved, to hit the field limits.
  task automatic test_full_scale();
    for (int i = 0; i < KEEP; i++) begin
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
    end
    send_sample(32767, 1'b1);
  endtask

  // More entries than the rows hold, with duplicates: exercise replacement
  // of the first matching entry and the floor/ceiling update.
  task automatic test_replacement();
    send_sample(3, 1'b0);
    send_sample(3, 1'b0);
    send_sample(3, 1'b0);
    send_sample(1, 1'b0);
    send_sample(3, 1'b0);
    send_sample(7, 1'b0);
    send_sample(2, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-1, 1'b1);
  endtask

  // Sample carried on the last transfer is inserted before averaging; a small
  // negative trimmed sum checks rounding toward minus infinity.
  task automatic test_last_carries_sample();
    send_sample(100, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(-1, 1'b1);
    send_sample(1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-32768, 1'b1);
  endtask

  function automatic int pick_sample(int mode);
    case (mode)
      0: return $urandom_range(0, 16) - 8;
      1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                     : -32768 + $urandom_range(0, 3);
      default: return $signed(16'($urandom_range(0, 65535)));
    endcase
  endfunction

  // Random frames, mostly short, some long enough to churn the rows.
  task automatic run_random_frames(input int item_target);
    int sent;
    int len;
    int mode;
    sent = 0;
    while (sent < item_target) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      mode = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(mode), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_random_phases();
    idle_pct = 0;   stall_pct = 0;
    run_random_frames(RANDOM_ITEMS / 4);
    idle_pct = 77;  stall_pct = 0;
    run_random_frames(RANDOM_ITEMS / 4);
    idle_pct = 0;   stall_pct = 77;
    run_random_frames(RANDOM_ITEMS / 4);
    idle_pct = 14;  stall_pct = 14;
    run_random_frames(RANDOM_ITEMS / 4);
  endtask

  // Bound the run; a hang ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    clear_rows();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_frames();
    test_full_scale();
    test_replacement();
    test_last_carries_sample();
    test_random_phases();

    // Drop valid, drain the pipeline, then allow the block's latency to pass.
    in_valid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (avg_expected.size() != 0) begin
      $error("%0d expected results never arrived", avg_expected.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
